// ----- design/qrm_pkg.sv -----
// Shared widths and constants for the quaternion to rotation matrix block.
package qrm_pkg;
  localparam int ONE_Q14 = 16384;
  localparam int Q_W = 15;      // quotient bits, enough for 0..16384
  localparam int PROD_W = 32;   // signed 16x16 product
  localparam int N_W = 33;      // squared norm, up to 2^32
  localparam int NUM_W = 34;    // signed numerator, magnitude up to n
  localparam int D_W = 34;      // divisor 2n
  localparam int R_W = 35;      // partial remainder before compare
  localparam int OUT_W = 16;
  localparam int NUM_ENT = 9;
  localparam int THR_W = 32;
  localparam logic [THR_W-1:0] THR_RESET = 32'd2;

  typedef logic signed [OUT_W-1:0] entry_t;
  typedef logic [N_W-1:0] mag_t;

  // Front end output for one item.
  typedef struct packed {
    logic valid;
    logic degen;
    logic [N_W-1:0] n;
  } front_ctl_t;
endpackage

// ----- design/qrm_front.sv -----
// Products, squared norm, numerators and sign split in three register stages.
module qrm_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  input  logic [qrm_pkg::THR_W-1:0] threshold,
  output qrm_pkg::front_ctl_t ctl,
  output qrm_pkg::mag_t mag [qrm_pkg::NUM_ENT],
  output logic neg [qrm_pkg::NUM_ENT]
);
  import qrm_pkg::*;

  logic signed [PROD_W-1:0] xx, yy, zz, ww, xy, xz, yz, xw, yw, zw;
  logic v1, v2;
  logic signed [NUM_W-1:0] num [NUM_ENT];
  logic [N_W-1:0] n2;
  logic signed [NUM_W-1:0] num_next [NUM_ENT];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    xx <= quat_x * quat_x;
    yy <= quat_y * quat_y;
    zz <= quat_z * quat_z;
    ww <= quat_w * quat_w;
    xy <= quat_x * quat_y;
    xz <= quat_x * quat_z;
    yz <= quat_y * quat_z;
    xw <= quat_x * quat_w;
    yw <= quat_y * quat_w;
    zw <= quat_z * quat_w;
  end

  always_comb begin
    num_next[0] = NUM_W'(xx) + NUM_W'(ww) - NUM_W'(yy) - NUM_W'(zz);
    num_next[1] = (NUM_W'(xy) - NUM_W'(zw)) <<< 1;
    num_next[2] = (NUM_W'(xz) + NUM_W'(yw)) <<< 1;
    num_next[3] = (NUM_W'(xy) + NUM_W'(zw)) <<< 1;
    num_next[4] = NUM_W'(yy) + NUM_W'(ww) - NUM_W'(xx) - NUM_W'(zz);
    num_next[5] = (NUM_W'(yz) - NUM_W'(xw)) <<< 1;
    num_next[6] = (NUM_W'(xz) - NUM_W'(yw)) <<< 1;
    num_next[7] = (NUM_W'(yz) + NUM_W'(xw)) <<< 1;
    num_next[8] = NUM_W'(zz) + NUM_W'(ww) - NUM_W'(xx) - NUM_W'(yy);
  end

  always_ff @(posedge clk) begin
    n2 <= N_W'(xx) + N_W'(yy) + N_W'(zz) + N_W'(ww);
    for (int i = 0; i < NUM_ENT; i++) num[i] <= num_next[i];
  end

  // Every numerator is bounded by n in magnitude, so the magnitude fits N_W.
  always_ff @(posedge clk) begin
    if (rst) ctl.valid <= 1'b0;
    else ctl.valid <= v2;
    ctl.n <= n2;
    ctl.degen <= (n2 == '0) || (n2 < N_W'(threshold));
    for (int i = 0; i < NUM_ENT; i++) begin
      neg[i] <= num[i][NUM_W-1];
      mag[i] <= num[i][NUM_W-1] ? N_W'(-num[i]) : N_W'(num[i]);
    end
  end
endmodule

// ----- design/qrm_div_lane.sv -----
// Pipelined restoring divider: round(mag * 2^14 / n), one quotient bit per stage.
module qrm_div_lane (
  input  logic clk,
  input  qrm_pkg::mag_t mag,
  input  logic [qrm_pkg::N_W-1:0] n,
  input  logic neg_in,
  output logic [qrm_pkg::Q_W-1:0] quot,
  output logic neg_out
);
  import qrm_pkg::*;

  // Dividend is mag*2^15 + n over divisor 2n, which rounds half away from zero.
  logic [R_W-1:0] rem [Q_W+1];
  logic [Q_W-1:0] low [Q_W+1];
  logic [Q_W-1:0] q [Q_W+1];
  logic [D_W-1:0] den [Q_W+1];
  logic sgn [Q_W+1];

  always_comb begin
    rem[0] = R_W'(mag) + R_W'(n >> Q_W);
    low[0] = n[Q_W-1:0];
    q[0] = '0;
    den[0] = {n, 1'b0};
    sgn[0] = neg_in;
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic [R_W-1:0] shifted;
    logic fits;
    assign shifted = {rem[s][R_W-2:0], low[s][Q_W-1]};
    assign fits = shifted >= R_W'(den[s]);
    always_ff @(posedge clk) begin
      rem[s+1] <= fits ? shifted - R_W'(den[s]) : shifted;
      low[s+1] <= {low[s][Q_W-2:0], 1'b0};
      q[s+1] <= {q[s][Q_W-2:0], fits};
      den[s+1] <= den[s];
      sgn[s+1] <= sgn[s];
    end
  end

  assign quot = q[Q_W];
  assign neg_out = sgn[Q_W];
endmodule

// ----- design/quaternion_to_rotation_matrix.sv -----
// Top level: configuration register, front end, nine divider lanes, output stage.
// Converts a Q4.12 quaternion to a normalized 3x3 rotation matrix in Q1.14. A request
// is taken in every cycle (busy stays low); its result appears with done high after
// three front stages (products, norm and numerators, sign split), fifteen divider
// stages, one for each quotient bit, and one output register.
// Results cannot be stalled and must be taken in the cycle they appear.
// degenerate_threshold sits at byte address 0 and should change only when idle.
module quaternion_to_rotation_matrix (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [15:0] quat_x,
  input  logic signed [15:0] quat_y,
  input  logic signed [15:0] quat_z,
  input  logic signed [15:0] quat_w,
  output logic done,
  output logic signed [15:0] m00,
  output logic signed [15:0] m01,
  output logic signed [15:0] m02,
  output logic signed [15:0] m10,
  output logic signed [15:0] m11,
  output logic signed [15:0] m12,
  output logic signed [15:0] m20,
  output logic signed [15:0] m21,
  output logic signed [15:0] m22,
  output logic degenerate,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import qrm_pkg::*;

  logic [THR_W-1:0] threshold;
  front_ctl_t fctl;
  mag_t mag [NUM_ENT];
  logic neg [NUM_ENT];
  logic [Q_W-1:0] quot [NUM_ENT];
  logic qneg [NUM_ENT];
  logic vpipe [Q_W+1];
  logic dpipe [Q_W+1];
  entry_t ent [NUM_ENT];

  assign busy = 1'b0;
  assign pready = 1'b1;
  assign prdata = threshold;

  // A single register occupies the whole address range.
  always_ff @(posedge clk) begin
    if (rst) threshold <= THR_RESET;
    else if (psel && penable && pwrite && (paddr[1:0] < 2'd3 || paddr == 2'd3))
      threshold <= pwdata;
  end

  qrm_front u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .threshold(threshold), .ctl(fctl), .mag(mag), .neg(neg)
  );

  for (genvar i = 0; i < NUM_ENT; i++) begin : g_lane
    qrm_div_lane u_lane (
      .clk(clk), .mag(mag[i]), .n(fctl.n), .neg_in(neg[i]),
      .quot(quot[i]), .neg_out(qneg[i])
    );
  end

  always_comb begin
    vpipe[0] = fctl.valid;
    dpipe[0] = fctl.degen;
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_ctl
    always_ff @(posedge clk) begin
      if (rst) vpipe[s+1] <= 1'b0;
      else vpipe[s+1] <= vpipe[s];
      dpipe[s+1] <= dpipe[s];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_ENT; i++) begin
      logic [Q_W-1:0] qc;
      qc = (quot[i] > Q_W'(ONE_Q14)) ? Q_W'(ONE_Q14) : quot[i];
      if (dpipe[Q_W])
        ent[i] = (i == 0 || i == 4 || i == 8) ? OUT_W'(ONE_Q14) : '0;
      else
        ent[i] = qneg[i] ? -OUT_W'(qc) : OUT_W'(qc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= vpipe[Q_W];
    m00 <= ent[0];
    m01 <= ent[1];
    m02 <= ent[2];
    m10 <= ent[3];
    m11 <= ent[4];
    m12 <= ent[5];
    m20 <= ent[6];
    m21 <= ent[7];
    m22 <= ent[8];
    degenerate <= dpipe[Q_W];
  end
endmodule

// ----- tb/quaternion_to_rotation_matrix_tb.sv -----
// Testbench for the quaternion to rotation matrix block: directed and random requests.
module quaternion_to_rotation_matrix_tb;
  import qrm_pkg::*;

  localparam int LATENCY = 19;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [1:0] ADDR_THRESHOLD = 2'd0;

  typedef struct {
    logic signed [15:0] ent [9];
    logic degen;
  } matrix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
  logic done;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic degenerate;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  matrix_t expected_matrices[$];
  logic [31:0] threshold;
  int idle_pct;
  int errors = 0;
  int requests_sent = 0;
  int results_seen = 0;
  int degenerate_seen = 0;
  int quiet_cycles = 0;

  quaternion_to_rotation_matrix DUT (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Rounds num * 2^14 / n to nearest, ties away from zero, clamped to one.
  function automatic logic signed [15:0] scaled_quotient(longint num, longint n);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = ((mag << 14) * 2 + n) / (n * 2);
    if (q > ONE_Q14) q = ONE_Q14;
    return (num < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic matrix_t rotation_of(logic signed [15:0] qx, logic signed [15:0] qy,
                                          logic signed [15:0] qz, logic signed [15:0] qw);
    matrix_t r;
    longint x, y, z, w, xx, yy, zz, n;
    x = qx; y = qy; z = qz; w = qw;
    xx = x * x; yy = y * y; zz = z * z;
    n = xx + yy + zz + w * w;
    if (n == 0 || n < longint'(threshold)) begin
      foreach (r.ent[i]) r.ent[i] = '0;
      r.ent[0] = 16'(ONE_Q14); r.ent[4] = 16'(ONE_Q14); r.ent[8] = 16'(ONE_Q14);
      r.degen = 1'b1;
    end else begin
      r.ent[0] = scaled_quotient(n - 2 * (yy + zz), n);
      r.ent[1] = scaled_quotient(2 * (x * y - z * w), n);
      r.ent[2] = scaled_quotient(2 * (x * z + y * w), n);
      r.ent[3] = scaled_quotient(2 * (x * y + z * w), n);
      r.ent[4] = scaled_quotient(n - 2 * (xx + zz), n);
      r.ent[5] = scaled_quotient(2 * (y * z - x * w), n);
      r.ent[6] = scaled_quotient(2 * (x * z - y * w), n);
      r.ent[7] = scaled_quotient(2 * (y * z + x * w), n);
      r.ent[8] = scaled_quotient(n - 2 * (xx + yy), n);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  // Sends one request, with a random gap before it according to idle_pct.
  task automatic send_quat(logic signed [15:0] qx, logic signed [15:0] qy,
                           logic signed [15:0] qz, logic signed [15:0] qw);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    quat_x <= qx; quat_y <= qy; quat_z <= qz; quat_w <= qw;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_matrices.push_back(rotation_of(qx, qy, qz, qw));
    requests_sent++;
  endtask

  task automatic pause_start();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    pause_start();
    while (expected_matrices.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_threshold(logic [31:0] value);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_THRESHOLD; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    threshold = value;
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_comp();
    case ($urandom_range(3))
      0: return 16'(16'sh8000 + $urandom_range(3));
      1: return 16'(16'sh7fff - $urandom_range(3));
      2: return 16'($urandom_range(8191) - 4096);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    idle_pct = 0;
    send_quat(0, 0, 0, 0);
    send_quat(0, 0, 0, 16'sd4096);
    send_quat(16'sd4096, 0, 0, 0);
    send_quat(0, 16'sd4096, 0, 0);
    send_quat(0, 0, 16'sd4096, 0);
    send_quat(16'sd2048, 16'sd2048, 16'sd2048, 16'sd2048);
    send_quat(-16'sd2048, 16'sd2048, -16'sd2048, 16'sd2048);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
    send_quat(0, 0, 0, 1);          // norm 1, below the reset threshold
    send_quat(0, 1, 0, 1);          // norm equals the threshold
    send_quat(1, 1, 0, 0);
    send_quat(3, 0, 0, 1);          // small values exercise rounding
    send_quat(-1, 2, -3, 4);
    send_quat(16'sd4096, 16'sd4096, 0, 0);
  endtask

  task automatic test_thresholds();
    write_threshold(32'd0);
    idle_pct = 0;
    send_quat(0, 0, 0, 0);         // zero norm still degenerate
    send_quat(0, 0, 0, 1);
    write_threshold(32'hffff_ffff);
    send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    write_threshold(32'h8000_0000);
    send_quat(16'sh8000, 16'sh8000, 0, 0);
    send_quat(16'sh8000, 16'sh7fff, 0, 0);
    write_threshold(32'd1 << 24);
    send_quat(16'sd4096, 0, 0, 0);
    send_quat(16'sd4095, 0, 0, 0);
  endtask

  task automatic test_random(int count, int pct);
    idle_pct = pct;
    repeat (count) send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
  endtask

  always @(posedge clk) begin
    matrix_t e;
    logic signed [15:0] got [9];
    if (!rst && done) begin
      got = '{m00, m01, m02, m10, m11, m12, m20, m21, m22};
      results_seen++;
      if (degenerate) degenerate_seen++;
      if (expected_matrices.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        e = expected_matrices.pop_front();
        foreach (got[i]) begin
          if (got[i] !== e.ent[i]) begin
            $error("m%0d%0d expected %0d got %0d", i / 3, i % 3, e.ent[i], got[i]);
            errors++;
          end
        end
        if (degenerate !== e.degen) begin
          $error("degenerate expected %0d got %0d", e.degen, degenerate);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    threshold = THR_RESET;
    idle_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    drain();
    test_thresholds();
    write_threshold(32'd2);
    test_random(220, 0);
    drain();
    test_random(220, 51);
    write_threshold($urandom);
    test_random(220, 16);
    write_threshold(32'd2);
    test_random(220, 0);
    drain();
    if (expected_matrices.size() != 0) begin
      $error("%0d results never arrived", expected_matrices.size());
      errors++;
    end
    $display("Sent %0d quaternions, checked %0d matrices (%0d degenerate),",
             requests_sent, results_seen, degenerate_seen);
    $display("over several threshold settings and sender gap rates.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
design/qrm_pkg.sv
design/qrm_front.sv
design/qrm_div_lane.sv
design/quaternion_to_rotation_matrix.sv
tb/quaternion_to_rotation_matrix_tb.sv
